[rtl/bmhpq_pkg.sv]
// Shared types, widths and codes for the binary max-heap priority queue.
`default_nettype none

package bmhpq_pkg;

  localparam int unsigned CAPACITY = 512;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned LO_W     = ADDR_W + 1;
  localparam int unsigned EXT_W    = ADDR_W + 2;
  localparam int unsigned KEY_W    = 16;
  localparam int unsigned TAG_W    = 16;
  localparam int unsigned OCC_W    = 10;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 48;
  localparam int unsigned M_USER_W = 3;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_REMOVE = 1'b1
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_RD,
    S_DN_CMP,
    S_OUT
  } state_e;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [TAG_W-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic ins_start;
    logic del_start;
    logic set_full;
    logic set_empty;
    logic up_rd;
    logic up_move;
    logic dn_load;
    logic dn_rd;
    logic dn_move;
    logic wr_mov;
  } ctrl_cmd_t;

  typedef struct packed {
    action_e action;
    logic    full;
    logic    empty;
    logic    pos_root;
    logic    parent_ge;
    logic    no_child;
    logic    stop_dn;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/binary_max_heap_priority_queue_core.sv]
// Top level of the binary max-heap priority queue: stream ports, controller and datapath.
//
// Usage:
//   The slave channel takes one transaction per item: tuser is the action
//   (insert or remove maximum), tdata carries the key and the tag of an insert.
//   The master channel returns exactly one transaction per item with the
//   removed entry, a status code and the occupancy after the item.
//   Items are handled one at a time; tready on the slave side is low from
//   acceptance until the result transaction has been taken.
//   An insert climbs toward the root and a remove descends toward a leaf, one
//   level per read-compare-write step of the single entry memory (one write
//   and two registered reads per cycle).
//   Refused items (insert when full, remove when empty) go straight to the
//   result and leave the memory untouched.
//   Reset empties the queue; memory contents are not cleared, and a read
//   may reach an entry that was never written, but its value is then unused.
//   When the receiver stalls, the result holds on the master channel and no
//   new item is accepted until it is taken.
`default_nettype none

module binary_max_heap_priority_queue_core
  import bmhpq_pkg::*;
(
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  wire [S_DATA_W-1:0]  s_axis_tdata_i,  // [15:0] insert_key, [31:16] insert_tag
  input  wire                 s_axis_tuser_i,  // [0] action
  output logic                m_axis_tvalid_o,
  input  wire                 m_axis_tready_i,
  output logic [M_DATA_W-1:0] m_axis_tdata_o,  // [15:0] out_key, [31:16] out_tag,
                                               // [41:32] occupancy, [47:42] zero
  output logic [M_USER_W-1:0] m_axis_tuser_o   // [0] out_valid, [2:1] status
);

  ctrl_cmd_t        cmd;
  dp_stat_t         stat;
  logic [KEY_W-1:0] res_key;
  logic [TAG_W-1:0] res_tag;
  logic             res_valid;
  status_e          res_status;
  logic [OCC_W-1:0] occupancy;

  bmhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bmhpq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .in_data_i    (s_axis_tdata_i),
    .in_action_i  (s_axis_tuser_i),
    .res_key_o    (res_key),
    .res_tag_o    (res_tag),
    .res_valid_o  (res_valid),
    .res_status_o (res_status),
    .occupancy_o  (occupancy)
  );

  assign m_axis_tdata_o = M_DATA_W'({occupancy, res_tag, res_key});
  assign m_axis_tuser_o = {res_status, res_valid};

endmodule

`default_nettype wire

[rtl/bmhpq_dp.sv]
// Datapath of the heap queue: entry memory, hole position, moving entry and result registers.
`default_nettype none

module bmhpq_dp
  import bmhpq_pkg::*;
(
  input  wire               clk_i,
  input  wire               rst_ni,
  input  ctrl_cmd_t         cmd_i,
  output dp_stat_t          stat_o,
  input  wire [S_DATA_W-1:0] in_data_i,
  input  wire               in_action_i,
  output logic [KEY_W-1:0]  res_key_o,
  output logic [TAG_W-1:0]  res_tag_o,
  output logic              res_valid_o,
  output status_e           res_status_o,
  output logic [OCC_W-1:0]  occupancy_o
);

  entry_t              mem_q [CAPACITY];
  entry_t              rd0_q, rd1_q;
  entry_t              mov_q;
  logic [ADDR_W-1:0]   pos_q;
  logic [ADDR_W-1:0]   par_q;
  logic [LO_W-1:0]     lo_q;
  logic [CNT_W-1:0]    count_q, count_d;
  logic [KEY_W-1:0]    res_key_q;
  logic [TAG_W-1:0]    res_tag_q;
  logic                res_valid_q;
  status_e             res_status_q;

  entry_t              in_entry;
  entry_t              pick_entry;
  entry_t              wdata;
  logic [ADDR_W-1:0]   par;
  logic [LO_W-1:0]     lo;
  logic [ADDR_W-1:0]   pick_addr;
  logic                lo_last;
  logic                pick_hi;
  logic                rd_en;
  logic                we;
  logic [ADDR_W-1:0]   raddr0, raddr1;
  logic [CNT_W-1:0]    count_dec;

  assign in_entry.key = in_data_i[KEY_W-1:0];
  assign in_entry.tag = in_data_i[KEY_W +: TAG_W];

  assign count_dec = count_q - CNT_W'(1);
  assign par       = ADDR_W'((pos_q - ADDR_W'(1)) >> 1);
  assign lo        = LO_W'({pos_q, 1'b1});
  assign lo_last   = (EXT_W'(lo_q) + EXT_W'(1)) == EXT_W'(count_q);
  assign pick_hi   = !lo_last && !($signed(rd0_q.key) > $signed(rd1_q.key));
  assign pick_entry = pick_hi ? rd1_q : rd0_q;
  assign pick_addr  = pick_hi ? lo_q[ADDR_W-1:0] + ADDR_W'(1) : lo_q[ADDR_W-1:0];

  assign stat_o.action    = action_e'(in_action_i);
  assign stat_o.full      = count_q == CNT_W'(CAPACITY);
  assign stat_o.empty     = count_q == '0;
  assign stat_o.pos_root  = pos_q == '0;
  assign stat_o.parent_ge = $signed(rd0_q.key) >= $signed(mov_q.key);
  assign stat_o.no_child  = EXT_W'(lo) >= EXT_W'(count_q);
  assign stat_o.stop_dn   = $signed(mov_q.key) >= $signed(pick_entry.key);

  always_comb begin
    rd_en  = cmd_i.del_start | cmd_i.up_rd | cmd_i.dn_rd;
    raddr0 = '0;
    raddr1 = '0;
    if (cmd_i.del_start) begin
      raddr1 = count_dec[ADDR_W-1:0];
    end else if (cmd_i.up_rd) begin
      raddr0 = par;
    end else if (cmd_i.dn_rd) begin
      raddr0 = lo[ADDR_W-1:0];
      raddr1 = lo[ADDR_W-1:0] + ADDR_W'(1);
    end
    we    = cmd_i.up_move | cmd_i.dn_move | cmd_i.wr_mov;
    wdata = mov_q;
    if (cmd_i.up_move) begin
      wdata = rd0_q;
    end else if (cmd_i.dn_move) begin
      wdata = pick_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[pos_q] <= wdata;
    end
    if (rd_en) begin
      rd0_q <= mem_q[raddr0];
      rd1_q <= mem_q[raddr1];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.ins_start) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.del_start) begin
      count_d = count_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins_start || cmd_i.del_start || cmd_i.set_full || cmd_i.set_empty) begin
      res_valid_q  <= 1'b0;
      res_key_q    <= '0;
      res_tag_q    <= '0;
      res_status_q <= cmd_i.set_full  ? STAT_FULL :
                      cmd_i.set_empty ? STAT_EMPTY : STAT_OK;
    end
    if (cmd_i.ins_start) begin
      mov_q <= in_entry;
      pos_q <= count_q[ADDR_W-1:0];
    end
    if (cmd_i.dn_load) begin
      res_valid_q <= 1'b1;
      res_key_q   <= rd0_q.key;
      res_tag_q   <= rd0_q.tag;
      mov_q       <= rd1_q;
      pos_q       <= '0;
    end
    if (cmd_i.up_rd) begin
      par_q <= par;
    end
    if (cmd_i.up_move) begin
      pos_q <= par_q;
    end
    if (cmd_i.dn_rd) begin
      lo_q <= lo;
    end
    if (cmd_i.dn_move) begin
      pos_q <= pick_addr;
    end
  end

  assign res_key_o    = res_key_q;
  assign res_tag_o    = res_tag_q;
  assign res_valid_o  = res_valid_q;
  assign res_status_o = res_status_q;
  assign occupancy_o  = OCC_W'(count_q);

endmodule

`default_nettype wire

[rtl/bmhpq_ctrl.sv]
// Controller state machine sequencing insert sift-up and remove sift-down.
`default_nettype none

module bmhpq_ctrl
  import bmhpq_pkg::*;
(
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire       out_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (stat_i.action == ACT_INSERT) begin
            if (stat_i.full) begin
              cmd_o.set_full = 1'b1;
              state_d        = S_OUT;
            end else begin
              cmd_o.ins_start = 1'b1;
              state_d         = S_UP_RD;
            end
          end else begin
            if (stat_i.empty) begin
              cmd_o.set_empty = 1'b1;
              state_d         = S_OUT;
            end else begin
              cmd_o.del_start = 1'b1;
              state_d         = S_DN_LOAD;
            end
          end
        end
      end
      S_UP_RD: begin
        if (stat_i.pos_root) begin
          cmd_o.wr_mov = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.up_rd = 1'b1;
          state_d     = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.parent_ge) begin
          cmd_o.wr_mov = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.up_move = 1'b1;
          state_d       = S_UP_RD;
        end
      end
      S_DN_LOAD: begin
        cmd_o.dn_load = 1'b1;
        state_d       = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat_i.no_child) begin
          cmd_o.wr_mov = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.dn_rd = 1'b1;
          state_d     = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat_i.stop_dn) begin
          cmd_o.wr_mov = 1'b1;
          state_d      = S_OUT;
        end else begin
          cmd_o.dn_move = 1'b1;
          state_d       = S_DN_RD;
        end
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bmhpq_checker.sv]
// Port-level checker for the heap queue core and its bind.
`default_nettype none

module bmhpq_checker
  import bmhpq_pkg::*;
(
  input wire                clk_i,
  input wire                rst_ni,
  input wire                s_tvalid_i,
  input wire                s_tready_i,
  input wire                m_tvalid_i,
  input wire                m_tready_i,
  input wire [M_USER_W-1:0] m_tuser_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result dropped while stalled");

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_tready_i && m_tvalid_i))
    else $error("input ready while a result is pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("second item accepted before result");

  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && m_tuser_i[0] |-> m_tuser_i[2:1] == STAT_OK)
    else $error("returned entry with error status");

endmodule

bind binary_max_heap_priority_queue_core bmhpq_checker u_bmhpq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
